// ===== src/fmnt_pkg.sv =====
package fmnt_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int CHAN_W    = 4;
	localparam int KEY_W     = 7;
	localparam int SKEY_W    = 9;
	localparam int OFS_W     = 6;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	// store geometry
	localparam int KEYS         = 128;
	localparam int CHANNELS_DEF = 16;

	// remainder unit: one quotient bit per cycle over the sum magnitude
	localparam int DIV_STEPS = OFS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// event kinds
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHOKE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EXPR     = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULO      = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0] SEED_FIRST_RST  = 5'sd0;
	localparam logic [CFG_W-1:0] SEED_SECOND_RST = 5'sd1;
	localparam logic [CFG_W-1:0] MODULO_RST      = 5'd12;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic load_out;
		logic store;
		logic div_start;
		logic div_step;
		logic div_last;
		logic cfg_wr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic note_on;
	} sts_t;

endpackage

// ===== src/fmnt_event_if.sv =====
interface fmnt_event_if;
	logic                         valid;
	logic                         ready;
	logic [fmnt_pkg::KIND_W-1:0]  kind;
	logic [fmnt_pkg::CHAN_W-1:0]  channel;
	logic [fmnt_pkg::KEY_W-1:0]   key;

	modport source (output valid, output kind, output channel, output key, input ready);
	modport sink (input valid, input kind, input channel, input key, output ready);
endinterface

// ===== src/fmnt_result_if.sv =====
interface fmnt_result_if;
	logic                               valid;
	logic                               ready;
	logic [fmnt_pkg::KIND_W-1:0]        out_kind;
	logic [fmnt_pkg::CHAN_W-1:0]        out_channel;
	logic signed [fmnt_pkg::SKEY_W-1:0] shifted_key;
	logic signed [fmnt_pkg::OFS_W-1:0]  applied_offset;

	modport source (output valid, output out_kind, output out_channel, output shifted_key,
		output applied_offset, input ready);
	modport sink (input valid, input out_kind, input out_channel, input shifted_key,
		input applied_offset, output ready);
endinterface

// ===== src/fmnt_cfg_if.sv =====
interface fmnt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fmnt_pkg::CFG_IDX_W-1:0]  index;
	logic [fmnt_pkg::CFG_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/fibonacci_mod_note_transposer.sv =====
// An accepted item passes from IDLE to EMIT and is loaded into the output register
// once that is empty or being read. Note-off, choke and expression items then return
// to IDLE; a note-on first runs the bit-serial remainder in DIV to form the next term.
// Reset: async, active low; the offset store is then cleared one entry per cycle over
// CHANNELS*128 entries (2048 by default), during which no item is taken.
module fibonacci_mod_note_transposer #(
	parameter int CHANNELS = fmnt_pkg::CHANNELS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	fmnt_event_if.sink      events,
	fmnt_result_if.source   results,
	fmnt_cfg_if.sink        cfg
);

	fmnt_pkg::cmd_t cmd;
	fmnt_pkg::sts_t sts;

	// sequencing and handshakes
	fmnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (events.valid),
		.in_ready  (events.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// offset store, sequence and result path
	fmnt_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (events.kind),
		.channel        (events.channel),
		.key            (events.key),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_kind       (results.out_kind),
		.out_channel    (results.out_channel),
		.shifted_key    (results.shifted_key),
		.applied_offset (results.applied_offset)
	);

endmodule

// ===== src/fmnt_ctrl.sv =====
module fmnt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  fmnt_pkg::sts_t   sts,
	output fmnt_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	localparam logic [fmnt_pkg::DIV_CNT_W-1:0] DIV_LAST =
		fmnt_pkg::DIV_CNT_W'(fmnt_pkg::DIV_STEPS - 1);

	logic [1:0]                       state_q;
	logic [1:0]                       state_nxt;
	logic [fmnt_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                             out_valid_q;

	// handshakes
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
	assign out_valid = out_valid_q;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.clr_wr    = (state_q == ST_CLEAR);
		cmd.load_in   = in_valid && in_ready;
		cmd.load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		cmd.store     = cmd.load_out && sts.note_on;
		cmd.div_start = cmd.load_out && sts.note_on;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_last  = (state_q == ST_DIV) && (div_cnt_q == DIV_LAST);
		cmd.cfg_wr    = cfg_valid && cfg_ready;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
			ST_IDLE:  if (cmd.load_in) state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (cmd.load_out) state_nxt = sts.note_on ? ST_DIV : ST_IDLE;
			end
			ST_DIV:   if (cmd.div_last) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// remainder step count
			if (cmd.div_start) div_cnt_q <= '0;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			// output register occupancy
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/fmnt_dp.sv =====
module fmnt_dp #(
	parameter int CHANNELS = fmnt_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fmnt_pkg::cmd_t                      cmd,
	output fmnt_pkg::sts_t                      sts,
	input  logic [fmnt_pkg::KIND_W-1:0]         kind,
	input  logic [fmnt_pkg::CHAN_W-1:0]         channel,
	input  logic [fmnt_pkg::KEY_W-1:0]          key,
	input  logic [fmnt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmnt_pkg::CFG_W-1:0]          cfg_data,
	output logic [fmnt_pkg::KIND_W-1:0]         out_kind,
	output logic [fmnt_pkg::CHAN_W-1:0]         out_channel,
	output logic signed [fmnt_pkg::SKEY_W-1:0]  shifted_key,
	output logic signed [fmnt_pkg::OFS_W-1:0]   applied_offset
);

	localparam int DEPTH  = CHANNELS * fmnt_pkg::KEYS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FULL_W = fmnt_pkg::CHAN_W + fmnt_pkg::KEY_W;
	localparam int OFS_W  = fmnt_pkg::OFS_W;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

	// offset store
	logic [OFS_W-1:0] mem [DEPTH];
	logic [OFS_W-1:0] rd_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// captured item
	logic [fmnt_pkg::KIND_W-1:0] kind_q;
	logic [fmnt_pkg::CHAN_W-1:0] chan_q;
	logic [fmnt_pkg::KEY_W-1:0]  key_q;
	logic                        chan_ok_q;

	// sequence and registers
	logic [fmnt_pkg::CFG_W-1:0] seed_first_q;
	logic [fmnt_pkg::CFG_W-1:0] seed_second_q;
	logic [fmnt_pkg::CFG_W-1:0] modulo_q;
	logic signed [OFS_W-1:0]    term_cur_q;
	logic signed [OFS_W-1:0]    term_prev_q;

	// remainder unit
	logic                 div_neg_q;
	logic [OFS_W-1:0]     div_mag_q;
	logic [OFS_W-1:0]     div_rem_q;
	logic [OFS_W-1:0]     rem_sh;
	logic [OFS_W-1:0]     rem_nxt;
	logic signed [OFS_W:0] sum;
	logic [OFS_W:0]       sum_abs;
	logic signed [OFS_W-1:0] term_nxt;

	logic [FULL_W-1:0] in_full;
	logic [FULL_W-1:0] st_full;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] st_addr;
	logic              in_chan_ok;
	logic signed [OFS_W-1:0] offset;

	assign in_full    = {channel, key};
	assign st_full    = {chan_q, key_q};
	assign in_addr    = in_full[ADDR_W-1:0];
	assign st_addr    = st_full[ADDR_W-1:0];
	assign in_chan_ok = {1'b0, channel} < (fmnt_pkg::CHAN_W + 1)'(CHANNELS);

	// status to controller
	always_comb begin
		sts.clr_last = (clr_addr_q == CLR_LAST);
		sts.note_on  = (kind_q == fmnt_pkg::KIND_NOTE_ON);
	end

	// store: clearing sweep, note-on write, registered read at accept
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) mem[clr_addr_q] <= '0;
		else if (cmd.store && chan_ok_q) mem[st_addr] <= term_cur_q;
		if (cmd.load_in) rd_q <= mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_addr_q <= '0;
		else if (cmd.clr_wr && !sts.clr_last) clr_addr_q <= clr_addr_q + 1'b1;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q    <= kind;
			chan_q    <= channel;
			key_q     <= key;
			chan_ok_q <= in_chan_ok;
		end
	end

	// offset selection and result register
	always_comb begin
		if (sts.note_on) offset = term_cur_q;
		else if (chan_ok_q) offset = rd_q;
		else offset = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind       <= kind_q;
			out_channel    <= chan_q;
			shifted_key    <= $signed({2'b00, key_q}) + fmnt_pkg::SKEY_W'(offset);
			applied_offset <= offset;
		end
	end

	// restoring remainder step
	assign sum     = (OFS_W + 1)'(term_cur_q) + (OFS_W + 1)'(term_prev_q);
	assign sum_abs = sum[OFS_W] ? (OFS_W + 1)'(-sum) : sum;
	assign rem_sh  = {div_rem_q[OFS_W-2:0], div_mag_q[OFS_W-1]};
	assign rem_nxt = (rem_sh >= {1'b0, modulo_q}) ? rem_sh - {1'b0, modulo_q} : rem_sh;

	always_comb begin
		if (modulo_q == '0) term_nxt = '0;
		else if (div_neg_q) term_nxt = -$signed(rem_nxt);
		else term_nxt = $signed(rem_nxt);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_neg_q <= sum[OFS_W];
			div_mag_q <= sum_abs[OFS_W-1:0];
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			div_mag_q <= {div_mag_q[OFS_W-2:0], 1'b0};
			div_rem_q <= rem_nxt;
		end
	end

	// registers and sequence terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_first_q  <= fmnt_pkg::SEED_FIRST_RST;
			seed_second_q <= fmnt_pkg::SEED_SECOND_RST;
			modulo_q      <= fmnt_pkg::MODULO_RST;
			term_cur_q    <= $signed({fmnt_pkg::SEED_FIRST_RST[4], fmnt_pkg::SEED_FIRST_RST});
			term_prev_q   <= $signed({fmnt_pkg::SEED_SECOND_RST[4], fmnt_pkg::SEED_SECOND_RST});
		end else if (cmd.cfg_wr) begin
			case (cfg_index)
				fmnt_pkg::CFG_SEED_FIRST: begin
					seed_first_q <= cfg_data;
					term_cur_q   <= $signed({cfg_data[4], cfg_data});
					term_prev_q  <= $signed({seed_second_q[4], seed_second_q});
				end
				fmnt_pkg::CFG_SEED_SECOND: begin
					seed_second_q <= cfg_data;
					term_cur_q    <= $signed({seed_first_q[4], seed_first_q});
					term_prev_q   <= $signed({cfg_data[4], cfg_data});
				end
				fmnt_pkg::CFG_MODULO: modulo_q <= cfg_data;
				default: ;
			endcase
		end else begin
			if (cmd.div_start) term_prev_q <= term_cur_q;
			if (cmd.div_last) term_cur_q <= term_nxt;
		end
	end

endmodule

// ===== verif/fibonacci_mod_note_transposer_tb.sv =====
`timescale 1ns / 1ps

module fibonacci_mod_note_transposer_tb;

	localparam int DUT_CHANNELS  = fmnt_pkg::CHANNELS_DEF;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 90;

	// index with no register behind it
	localparam logic [fmnt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic [fmnt_pkg::KIND_W-1:0]        kind;
		logic [fmnt_pkg::CHAN_W-1:0]        chan;
		logic signed [fmnt_pkg::SKEY_W-1:0] skey;
		logic signed [fmnt_pkg::OFS_W-1:0]  ofs;
	} note_result_t;

	logic clk;
	logic arst_n;

	fmnt_event_if  note_in();
	fmnt_result_if note_out();
	fmnt_cfg_if    reg_wr();

	fibonacci_mod_note_transposer #(
		.CHANNELS(DUT_CHANNELS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.events (note_in),
		.results(note_out),
		.cfg    (reg_wr)
	);

	// shadow of the sequence, registers and offset store
	int seed_a;
	int seed_b;
	int mod_div;
	int fib_cur;
	int fib_prev;
	logic signed [fmnt_pkg::OFS_W-1:0] offset_mem [DUT_CHANNELS*fmnt_pkg::KEYS];

	note_result_t pending_notes [$];
	int errors;
	int cycle_count;

	// sender burst control
	int burst_left;
	bit steady_send;

	// receiver stall control
	int hold_req;
	int hold_left;
	int stall_mode;
	int mode_left;
	int stall_tick;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// --------------------------------------------------------------
	// shadow model
	// --------------------------------------------------------------
	task automatic reset_shadow();
		seed_a   = int'($signed(fmnt_pkg::SEED_FIRST_RST));
		seed_b   = int'($signed(fmnt_pkg::SEED_SECOND_RST));
		mod_div  = int'(fmnt_pkg::MODULO_RST);
		fib_cur  = seed_a;
		fib_prev = seed_b;
		foreach (offset_mem[i])
			offset_mem[i] = '0;
	endtask

	// offset for one note event; a note-on also steps the sequence
	function automatic note_result_t transpose_note(input logic [fmnt_pkg::KIND_W-1:0] kind,
			input logic [fmnt_pkg::CHAN_W-1:0] ch, input logic [fmnt_pkg::KEY_W-1:0] key);
		note_result_t r;
		logic signed [fmnt_pkg::OFS_W-1:0] ofs;
		int slot;
		int sum;
		slot = int'(ch) * fmnt_pkg::KEYS + int'(key);
		if (kind == fmnt_pkg::KIND_NOTE_ON) begin
			ofs = fmnt_pkg::OFS_W'(fib_cur);
			if (int'(ch) < DUT_CHANNELS)
				offset_mem[slot] = ofs;
			sum      = fib_cur + fib_prev;
			fib_prev = fib_cur;
			// truncating remainder, sign follows the sum
			fib_cur  = (mod_div == 0) ? 0 : sum % mod_div;
		end else begin
			ofs = (int'(ch) < DUT_CHANNELS) ? offset_mem[slot] : '0;
		end
		r.kind = kind;
		r.chan = ch;
		r.skey = fmnt_pkg::SKEY_W'(int'(key) + int'(ofs));
		r.ofs  = ofs;
		return r;
	endfunction

	// --------------------------------------------------------------
	// drivers
	// --------------------------------------------------------------
	task automatic send_note(input logic [fmnt_pkg::KIND_W-1:0] kind,
			input logic [fmnt_pkg::CHAN_W-1:0] ch, input logic [fmnt_pkg::KEY_W-1:0] key);
		int gap;
		if (!steady_send && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			note_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		note_in.valid   <= 1'b1;
		note_in.kind    <= kind;
		note_in.channel <= ch;
		note_in.key     <= key;
		@(posedge clk);
		while (!note_in.ready)
			@(posedge clk);
		pending_notes.push_back(transpose_note(kind, ch, key));
	endtask

	// any kind, channel and key
	task automatic send_random_note();
		send_note(fmnt_pkg::KIND_W'($urandom_range(0, 3)),
			fmnt_pkg::CHAN_W'($urandom_range(0, 15)),
			fmnt_pkg::KEY_W'($urandom_range(0, 127)));
	endtask

	task automatic write_reg(input logic [fmnt_pkg::CFG_IDX_W-1:0] idx,
			input logic [fmnt_pkg::CFG_W-1:0] val);
		reg_wr.valid <= 1'b1;
		reg_wr.index <= idx;
		reg_wr.data  <= val;
		@(posedge clk);
		while (!reg_wr.ready)
			@(posedge clk);
		case (idx)
			fmnt_pkg::CFG_SEED_FIRST: begin
				seed_a   = int'($signed(val));
				fib_cur  = seed_a;
				fib_prev = seed_b;
			end
			fmnt_pkg::CFG_SEED_SECOND: begin
				seed_b   = int'($signed(val));
				fib_cur  = seed_a;
				fib_prev = seed_b;
			end
			fmnt_pkg::CFG_MODULO: mod_div = int'(val);
			default: ;
		endcase
	endtask

	// one register phase; only called with the block idle
	task automatic program_regs(input logic [fmnt_pkg::CFG_W-1:0] first,
			input logic [fmnt_pkg::CFG_W-1:0] second, input logic [fmnt_pkg::CFG_W-1:0] div,
			input bit seeds, input bit div_too);
		if (div_too)
			write_reg(fmnt_pkg::CFG_MODULO, div);
		if (seeds) begin
			write_reg(fmnt_pkg::CFG_SEED_FIRST, first);
			write_reg(fmnt_pkg::CFG_SEED_SECOND, second);
		end
		reg_wr.valid <= 1'b0;
	endtask

	// stop offering, wait for every result, then let the remainder unit finish
	task automatic wait_drain();
		note_in.valid <= 1'b0;
		burst_left = 0;
		while (pending_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// --------------------------------------------------------------
	// receiver: stall pattern plus requested long hold-offs
	// --------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(32, 256);
		end else begin
			mode_left--;
		end
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			note_out.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: note_out.ready <= 1'b1;
				1: note_out.ready <= 1'($urandom_range(0, 1));
				2: note_out.ready <= (stall_tick % 4 == 0);
				default: note_out.ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// --------------------------------------------------------------
	// result checker
	// --------------------------------------------------------------
	always @(posedge clk) begin
		note_result_t want;
		if (arst_n && note_out.valid && note_out.ready) begin
			if (pending_notes.size() == 0) begin
				$error("result with nothing expected: kind %0d channel %0d key %0d",
					note_out.out_kind, note_out.out_channel, $signed(note_out.shifted_key));
				errors++;
			end else begin
				want = pending_notes.pop_front();
				if (note_out.out_kind !== want.kind) begin
					$error("out_kind: expected %0d, got %0d", want.kind, note_out.out_kind);
					errors++;
				end
				if (note_out.out_channel !== want.chan) begin
					$error("out_channel: expected %0d, got %0d", want.chan,
						note_out.out_channel);
					errors++;
				end
				if (note_out.shifted_key !== want.skey) begin
					$error("shifted_key: expected %0d, got %0d", want.skey,
						note_out.shifted_key);
					errors++;
				end
				if (note_out.applied_offset !== want.ofs) begin
					$error("applied_offset: expected %0d, got %0d", want.ofs,
						note_out.applied_offset);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// --------------------------------------------------------------
	// tests
	// --------------------------------------------------------------

	// every kind, extreme channels and keys, unwritten slots, overwrite
	task automatic test_kinds_directed();
		send_note(fmnt_pkg::KIND_EXPR, 4'd0, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_OFF, 4'd15, 7'd127);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd0, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd15, 7'd127);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd0, 7'd127);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd15, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_OFF, 4'd15, 7'd127);
		send_note(fmnt_pkg::KIND_CHOKE, 4'd0, 7'd127);
		send_note(fmnt_pkg::KIND_EXPR, 4'd15, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_OFF, 4'd0, 7'd0);
		// a second note-on replaces the stored offset
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd15, 7'd127);
		send_note(fmnt_pkg::KIND_CHOKE, 4'd15, 7'd127);
		wait_drain();
	endtask

	// sign extremes of key and offset, zero divisor, seeds out of range
	task automatic test_config_extremes();
		// most negative: -12 then -23 on key 0
		program_regs(fmnt_pkg::CFG_W'(-12), fmnt_pkg::CFG_W'(-11), 5'd24, 1'b1, 1'b1);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd5, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd6, 7'd0);
		send_note(fmnt_pkg::KIND_NOTE_OFF, 4'd6, 7'd0);
		send_note(fmnt_pkg::KIND_EXPR, 4'd5, 7'd0);
		wait_drain();
		// most positive: 12 then 23 on key 127
		program_regs(fmnt_pkg::CFG_W'(12), fmnt_pkg::CFG_W'(11), 5'd24, 1'b1, 1'b0);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd9, 7'd127);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd9, 7'd127);
		send_note(fmnt_pkg::KIND_CHOKE, 4'd9, 7'd127);
		wait_drain();
		// zero divisor; the sequence is not reloaded
		program_regs('0, '0, 5'd0, 1'b0, 1'b1);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd3, 7'd64);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd3, 7'd65);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd3, 7'd66);
		wait_drain();
		// seeds and divisor beyond the usual range
		program_regs(5'b10000, 5'b01111, 5'd31, 1'b1, 1'b1);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd1, 7'd10);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd2, 7'd100);
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd1, 7'd11);
		send_note(fmnt_pkg::KIND_NOTE_OFF, 4'd1, 7'd10);
		wait_drain();
		// write to the unused index changes nothing
		write_reg(CFG_SPARE, 5'b11111);
		reg_wr.valid <= 1'b0;
		send_note(fmnt_pkg::KIND_NOTE_ON, 4'd7, 7'd42);
		send_note(fmnt_pkg::KIND_EXPR, 4'd7, 7'd42);
		wait_drain();
	endtask

	// long receiver hold-off while items keep coming
	task automatic test_receiver_hold();
		hold_req    = HOLD_CYCLES;
		steady_send = 1'b1;
		repeat (30)
			send_random_note();
		steady_send = 1'b0;
		wait_drain();
	endtask

	// sender stops until everything has come back, then resumes
	task automatic test_sender_pause();
		repeat (12)
			send_random_note();
		wait_drain();
		repeat (12)
			send_random_note();
		wait_drain();
	endtask

	// random register phases, mostly note-on followed by events on the same slot
	task automatic test_random_phases();
		int act_ch [$];
		int act_key [$];
		int pick;
		int seed_v1;
		int seed_v2;
		int div_v;
		logic [fmnt_pkg::KIND_W-1:0] kind;
		for (int ph = 0; ph < PHASES; ph++) begin
			if ($urandom_range(0, 4) == 0) begin
				seed_v1 = $urandom_range(0, 31);
				seed_v2 = $urandom_range(0, 31);
				case ($urandom_range(0, 3))
					0: div_v = 0;
					1: div_v = 1;
					2: div_v = 24;
					default: div_v = 31;
				endcase
			end else begin
				seed_v1 = $urandom_range(0, 24) - 12;
				seed_v2 = $urandom_range(0, 24) - 12;
				div_v   = $urandom_range(1, 24);
			end
			program_regs(fmnt_pkg::CFG_W'(seed_v1), fmnt_pkg::CFG_W'(seed_v2),
				fmnt_pkg::CFG_W'(div_v), $urandom_range(0, 3) != 0,
				$urandom_range(0, 2) != 0);
			act_ch.delete();
			act_key.delete();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise
					send_random_note();
				end else if (act_ch.size() < 3 || $urandom_range(0, 3) == 0) begin
					act_ch.push_back($urandom_range(0, 15));
					act_key.push_back($urandom_range(0, 127));
					send_note(fmnt_pkg::KIND_NOTE_ON, fmnt_pkg::CHAN_W'(act_ch[$]),
						fmnt_pkg::KEY_W'(act_key[$]));
				end else begin
					pick = $urandom_range(0, act_ch.size() - 1);
					case ($urandom_range(0, 2))
						0: kind = fmnt_pkg::KIND_NOTE_OFF;
						1: kind = fmnt_pkg::KIND_CHOKE;
						default: kind = fmnt_pkg::KIND_EXPR;
					endcase
					send_note(kind, fmnt_pkg::CHAN_W'(act_ch[pick]),
						fmnt_pkg::KEY_W'(act_key[pick]));
					// note ended
					if (kind != fmnt_pkg::KIND_EXPR) begin
						act_ch.delete(pick);
						act_key.delete(pick);
					end
				end
			end
			wait_drain();
		end
	endtask

	// --------------------------------------------------------------
	// main sequence
	// --------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		note_in.valid   = 1'b0;
		note_in.kind    = fmnt_pkg::KIND_NOTE_ON;
		note_in.channel = '0;
		note_in.key     = '0;
		note_out.ready  = 1'b0;
		reg_wr.valid    = 1'b0;
		reg_wr.index    = fmnt_pkg::CFG_SEED_FIRST;
		reg_wr.data     = '0;
		errors          = 0;
		cycle_count     = 0;
		burst_left      = 0;
		steady_send     = 1'b0;
		hold_req        = 0;
		hold_left       = 0;
		stall_mode      = 0;
		mode_left       = 0;
		stall_tick      = 0;
		reset_shadow();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_kinds_directed();
		test_config_extremes();
		test_receiver_hold();
		test_sender_pause();
		test_random_phases();
		wait_drain();

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/fmnt_pkg.sv
src/fmnt_event_if.sv
src/fmnt_result_if.sv
src/fmnt_cfg_if.sv
src/fmnt_ctrl.sv
src/fmnt_dp.sv
src/fibonacci_mod_note_transposer.sv
verif/fibonacci_mod_note_transposer_tb.sv
